@@ sv/temp_sensor_moving_average_macros.svh @@
// Assertion helpers for the top-level RTL.
`ifndef TEMP_SENSOR_MOVING_AVERAGE_MACROS_SVH
`define TEMP_SENSOR_MOVING_AVERAGE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

@@ sv/tsma_pkg.sv @@
package tsma_pkg;

   localparam int AdcW     = 12;
   localparam int CW       = 19;
   localparam int FW       = 20;
   localparam int WinLen   = 20;
   localparam int ReqDataW = 16;
   localparam int RspDataW = 80;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_CALC,
      FR_MUL,
      FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // F = (9*C + 16000) / 5 in hundredths, rounded to nearest.
   localparam int C2fVW      = 22;
   localparam int C2fXW      = 21;
   localparam int C2fShift   = 24;
   localparam int C2fRecipW  = 22;
   localparam int C2fProdW   = C2fXW + C2fRecipW;
   localparam int FahrScale  = 9;
   localparam int FahrOffset = 16000;
   localparam int FahrDiv    = 5;
   localparam logic [C2fRecipW-1:0] C2fRecip =
      C2fRecipW'(((64'd1 << C2fShift) + 64'(FahrDiv) - 64'd1) / 64'(FahrDiv));

   function automatic logic signed [FW-1:0] c_to_f(input logic signed [CW-1:0] c);
      logic signed [C2fVW-1:0] v;
      logic [C2fVW-1:0]        mag;
      logic [C2fXW-1:0]        x;
      logic [C2fProdW-1:0]     prod;
      logic [FW-2:0]           q;
      v    = C2fVW'(c) * C2fVW'(FahrScale) + C2fVW'(FahrOffset);
      mag  = v[C2fVW-1] ? C2fVW'(-v) : C2fVW'(v);
      // round half up on the magnitude: floor((mag + 2) / 5)
      x    = C2fXW'(mag) + C2fXW'(FahrDiv / 2);
      prod = C2fProdW'(x) * C2fProdW'(C2fRecip);
      q    = prod[C2fShift +: FW-1];
      return v[C2fVW-1] ? -FW'(q) : FW'(q);
   endfunction

endpackage

@@ sv/tsma_front.sv @@
module tsma_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tsma_pkg::AdcW-1:0]            adc_sample,
   input  tsma_pkg::queue_status_type           q_stat,
   output logic                                 q_push,
   output logic signed [tsma_pkg::CW-1:0]       q_wdata
);

   localparam int CW       = tsma_pkg::CW;
   localparam int AdcW     = tsma_pkg::AdcW;
   localparam int NW       = 35;
   localparam int PreShift = 6;
   localparam int TW       = 28;
   localparam int DivShift = 39;
   localparam int RecipW   = 29;
   localparam int ProdW    = TW + RecipW;
   // numerator and divisor of the Celsius formula, both reduced by four
   localparam logic [NW-1:0] NumBase   = 35'd2407894400;
   localparam logic [NW-1:0] AdcGain   = 35'd2578125;
   localparam logic [NW-1:0] RoundBias = 35'd55072;
   localparam longint unsigned CDivisor = 64'd1721;
   localparam logic [RecipW-1:0] CRecip =
      RecipW'(((64'd1 << DivShift) + CDivisor - 64'd1) / CDivisor);

   tsma_pkg::front_state_type state_ff, state_in;
   logic [AdcW-1:0]  adc_ff, adc_in;
   logic             neg_ff, neg_in;
   logic [TW-1:0]    t_ff, t_in;
   logic [ProdW-1:0] prod_ff, prod_in;

   logic [NW-1:0]    n;
   logic [NW-1:0]    mag;
   logic [NW-1:0]    tsum;
   logic [CW-2:0]    q;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsma_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      adc_ff  <= adc_in;
      neg_ff  <= neg_in;
      t_ff    <= t_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      state_in   = state_ff;
      adc_in     = adc_ff;
      neg_in     = neg_ff;
      t_in       = t_ff;
      prod_in    = prod_ff;
      req_tready = 1'b0;
      q_push     = 1'b0;

      n    = NumBase - AdcGain * NW'(adc_ff);
      mag  = n[NW-1] ? -n : n;
      // 2*|n| + divisor, then drop the power-of-two part of 2*divisor
      tsum = (mag << 1) + RoundBias;
      q    = prod_ff[DivShift +: CW-1];
      q_wdata = neg_ff ? -CW'(q) : CW'(q);

      unique case (state_ff)
         tsma_pkg::FR_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               adc_in   = adc_sample;
               state_in = tsma_pkg::FR_CALC;
            end
         end
         tsma_pkg::FR_CALC: begin
            neg_in   = n[NW-1];
            t_in     = tsum[PreShift +: TW];
            state_in = tsma_pkg::FR_MUL;
         end
         tsma_pkg::FR_MUL: begin
            prod_in  = ProdW'(t_ff) * ProdW'(CRecip);
            state_in = tsma_pkg::FR_PUSH;
         end
         tsma_pkg::FR_PUSH: begin
            // hold until the queue has room
            if (!q_stat.full) begin
               q_push   = 1'b1;
               state_in = tsma_pkg::FR_IDLE;
            end
         end
         default: state_in = tsma_pkg::FR_IDLE;
      endcase
   end

endmodule

@@ sv/tsma_fifo.sv @@
module tsma_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic signed [tsma_pkg::CW-1:0]  wdata,
   input  logic                            pop,
   output logic signed [tsma_pkg::CW-1:0]  rdata,
   output tsma_pkg::queue_status_type      q_stat
);

   localparam int CW    = tsma_pkg::CW;
   localparam int Depth = 2;
   localparam int PtrW  = $clog2(Depth);

   logic signed [CW-1:0] slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      count_in     = count_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
      rdata        = slot_ff[rd_ptr_ff];
      q_stat.full  = (count_ff == (PtrW+1)'(Depth));
      q_stat.empty = (count_ff == '0);
   end

endmodule

@@ sv/tsma_back.sv @@
module tsma_back (
   input  logic                            clock,
   input  logic                            reset,
   input  tsma_pkg::queue_status_type      q_stat,
   input  logic signed [tsma_pkg::CW-1:0]  q_rdata,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic signed [tsma_pkg::CW-1:0]  temp_c,
   output logic signed [tsma_pkg::FW-1:0]  temp_f,
   output logic signed [tsma_pkg::CW-1:0]  avg_c,
   output logic signed [tsma_pkg::FW-1:0]  avg_f,
   output logic                            avg_valid
);

   localparam int CW        = tsma_pkg::CW;
   localparam int FW        = tsma_pkg::FW;
   localparam int WinLen    = tsma_pkg::WinLen;
   localparam int PosW      = $clog2(WinLen);
   localparam int SumW      = CW + $clog2(WinLen);
   localparam int AvgXW     = SumW + 1;
   localparam int AvgDiv    = 2 * WinLen;
   localparam int AvgShift  = AvgXW + $clog2(AvgDiv);
   localparam int AvgRecipW = AvgXW + 1;
   localparam int AProdW    = AvgXW + AvgRecipW;
   localparam logic [AvgRecipW-1:0] AvgRecip =
      AvgRecipW'(((64'd1 << AvgShift) + 64'(AvgDiv) - 64'd1) / 64'(AvgDiv));

   tsma_pkg::back_state_type state_ff, state_in;
   logic signed [CW-1:0]   c_ff, c_in;
   logic signed [FW-1:0]   f_ff, f_in;
   logic signed [CW-1:0]   store_ff [WinLen];
   logic signed [CW-1:0]   old_ff;
   logic signed [SumW-1:0] sum_ff, sum_in;
   logic [PosW-1:0]        pos_ff, pos_in;
   logic                   full_ff, full_in;
   logic                   aneg_ff, aneg_in;
   logic [AProdW-1:0]      aprod_ff, aprod_in;
   logic signed [CW-1:0]   avg_c_ff, avg_c_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0]   out_temp_c_ff, out_temp_c_in;
   logic signed [FW-1:0]   out_temp_f_ff, out_temp_f_in;
   logic signed [CW-1:0]   out_avg_c_ff, out_avg_c_in;
   logic signed [FW-1:0]   out_avg_f_ff, out_avg_f_in;
   logic                   out_avg_valid_ff, out_avg_valid_in;

   logic signed [CW-1:0]   old_c;
   logic [SumW-1:0]        amag;
   logic [AvgXW-1:0]       ax;
   logic [CW-2:0]          aq;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsma_pkg::BK_IDLE;
         sum_ff       <= '0;
         pos_ff       <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      c_ff             <= c_in;
      f_ff             <= f_in;
      aneg_ff          <= aneg_in;
      aprod_ff         <= aprod_in;
      avg_c_ff         <= avg_c_in;
      out_temp_c_ff    <= out_temp_c_in;
      out_temp_f_ff    <= out_temp_f_in;
      out_avg_c_ff     <= out_avg_c_in;
      out_avg_f_ff     <= out_avg_f_in;
      out_avg_valid_ff <= out_avg_valid_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         store_ff[pos_ff] <= q_rdata;
      end
      // fetch the entry that the next beat overwrites
      old_ff <= store_ff[pos_in];
   end

   always_comb begin
      state_in         = state_ff;
      c_in             = c_ff;
      f_in             = f_ff;
      sum_in           = sum_ff;
      pos_in           = pos_ff;
      full_in          = full_ff;
      aneg_in          = aneg_ff;
      aprod_in         = aprod_ff;
      avg_c_in         = avg_c_ff;
      out_temp_c_in    = out_temp_c_ff;
      out_temp_f_in    = out_temp_f_ff;
      out_avg_c_in     = out_avg_c_ff;
      out_avg_f_in     = out_avg_f_ff;
      out_avg_valid_in = out_avg_valid_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      q_pop            = 1'b0;

      // entries ahead of the write position count as zero until the ring fills
      old_c = full_ff ? old_ff : '0;
      amag  = sum_ff[SumW-1] ? SumW'(-sum_ff) : SumW'(sum_ff);
      ax    = {amag, 1'b0} + AvgXW'(WinLen);
      aq    = aprod_ff[AvgShift +: CW-1];

      unique case (state_ff)
         tsma_pkg::BK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop  = 1'b1;
               c_in   = q_rdata;
               f_in   = tsma_pkg::c_to_f(q_rdata);
               sum_in = sum_ff - SumW'(old_c) + SumW'(q_rdata);
               if (pos_ff == PosW'(WinLen - 1)) begin
                  pos_in  = '0;
                  full_in = 1'b1;
               end else begin
                  pos_in = pos_ff + PosW'(1);
               end
               state_in = tsma_pkg::BK_MUL;
            end
         end
         tsma_pkg::BK_MUL: begin
            aneg_in  = sum_ff[SumW-1];
            aprod_in = AProdW'(ax) * AProdW'(AvgRecip);
            state_in = tsma_pkg::BK_DIV;
         end
         tsma_pkg::BK_DIV: begin
            avg_c_in = full_ff ? (aneg_ff ? -CW'(aq) : CW'(aq)) : '0;
            state_in = tsma_pkg::BK_OUT;
         end
         tsma_pkg::BK_OUT: begin
            // load the output register once it is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in     = 1'b1;
               out_temp_c_in    = c_ff;
               out_temp_f_in    = f_ff;
               out_avg_c_in     = avg_c_ff;
               out_avg_f_in     = full_ff ? tsma_pkg::c_to_f(avg_c_ff) : '0;
               out_avg_valid_in = full_ff;
               state_in         = tsma_pkg::BK_IDLE;
            end
         end
         default: state_in = tsma_pkg::BK_IDLE;
      endcase

      rsp_tvalid = rsp_valid_ff;
      temp_c     = out_temp_c_ff;
      temp_f     = out_temp_f_ff;
      avg_c      = out_avg_c_ff;
      avg_f      = out_avg_f_ff;
      avg_valid  = out_avg_valid_ff;
   end

endmodule

@@ sv/temp_sensor_moving_average.sv @@
// Converts raw 12-bit temperature-sensor ADC readings to hundredths of a degree
// Celsius and Fahrenheit and keeps a 20-sample moving average of the Celsius
// value. Each input beat carries one reading in req_tdata[11:0] and yields
// exactly one result beat. The average fields read zero and rsp_tuser stays low
// until twenty readings have been taken; the twentieth result is the first one
// with a valid average. The front end latches a reading, applies the linear
// scaling, does a reciprocal multiply for the divide by the sensor slope and
// pushes the result into the queue; the back end updates the ring and running
// sum, does the average multiply, rounds, and converts to Fahrenheit into the
// output register. A two-entry queue between them lets them overlap, so the
// front end can take a new reading while the back end still works on the last;
// a full queue holds it off. Synchronous active-high reset clears the window.
module temp_sensor_moving_average (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // adc_sample [11:0], zero [15:12]
   input  logic [tsma_pkg::ReqDataW-1:0]     req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // temp_c [18:0], temp_f [38:19], avg_c [57:39], avg_f [77:58], zero [79:78]
   output logic [tsma_pkg::RspDataW-1:0]     rsp_tdata,
   // avg_valid [0]
   output logic                              rsp_tuser
);

`include "temp_sensor_moving_average_macros.svh"

   localparam int CW     = tsma_pkg::CW;
   localparam int FW     = tsma_pkg::FW;
   localparam int RspPad = tsma_pkg::RspDataW - 2 * CW - 2 * FW;

   tsma_pkg::queue_status_type q_stat;
   logic                 q_push;
   logic                 q_pop;
   logic signed [CW-1:0] q_wdata;
   logic signed [CW-1:0] q_rdata;
   logic signed [CW-1:0] temp_c;
   logic signed [FW-1:0] temp_f;
   logic signed [CW-1:0] avg_c;
   logic signed [FW-1:0] avg_f;
   logic                 avg_valid;

   tsma_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .adc_sample (req_tdata[tsma_pkg::AdcW-1:0]),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   tsma_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .q_stat (q_stat)
   );

   tsma_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_rdata    (q_rdata),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .temp_c     (temp_c),
      .temp_f     (temp_f),
      .avg_c      (avg_c),
      .avg_f      (avg_f),
      .avg_valid  (avg_valid)
   );

   assign rsp_tdata = {{RspPad{1'b0}}, avg_f, avg_c, temp_f, temp_c};
   assign rsp_tuser = avg_valid;

   `ASSERT_IMPLY(a_push_has_room, clock, reset, q_push, !q_stat.full)
   `ASSERT_IMPLY(a_pop_has_data, clock, reset, q_pop, !q_stat.empty)
   `ASSERT_IMPLY(a_avg_zero_early, clock, reset, rsp_tvalid && !rsp_tuser, !(|avg_c) && !(|avg_f))
   `ASSERT_NEXT(a_front_busy_after_beat, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

@@ tb/temp_sensor_moving_average_test.sv @@
`timescale 1ns / 1ps

module temp_sensor_moving_average_test;

   localparam int CW           = tsma_pkg::CW;
   localparam int FW           = tsma_pkg::FW;
   localparam int AdcW         = tsma_pkg::AdcW;
   localparam int WinLen       = tsma_pkg::WinLen;
   localparam int ReqDataW     = tsma_pkg::ReqDataW;
   localparam int RspDataW     = tsma_pkg::RspDataW;
   localparam int TempFLsb     = CW;
   localparam int AvgCLsb      = CW + FW;
   localparam int AvgFLsb      = 2 * CW + FW;
   localparam int LongHold     = 300;
   localparam int SettleCycles = 16;
   localparam int RandomItems  = 1785;

   typedef struct {
      logic signed [CW-1:0] temp_c;
      logic signed [FW-1:0] temp_f;
      logic signed [CW-1:0] avg_c;
      logic signed [FW-1:0] avg_f;
      logic                 avg_valid;
   } reading_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tuser;

   // predictor copy of the averaging window
   longint window_c [WinLen];
   longint window_total;
   int     ring_pos;
   bit     ring_full;

   reading_type pending_readings[$];
   reading_type oldest_reading;
   int          mismatch_count;
   int          results_seen;

   // receiver stall pattern and long hold-off
   int          hold_req_count;
   int          hold_served;
   int          hold_left;
   int          pattern_age;
   logic [15:0] ready_pattern;

   temp_sensor_moving_average u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // Round to nearest, ties away from zero; den is positive.
   function automatic longint round_half_away(input longint num, input longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q   = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint fahrenheit_of(input longint cent_c);
      return round_half_away(9 * cent_c + 16000, 5);
   endfunction

   function automatic reading_type predict_reading(input logic [AdcW-1:0] adc);
      reading_type r;
      longint      code;
      longint      c;
      longint      f;
      longint      ac;
      longint      af;
      code = longint'(adc);
      c = round_half_away(2700 * 64'sd220288 + (64'sd2891776 - 3300 * code) * 3125,
                          64'sd220288);
      f = fahrenheit_of(c);
      window_total       = window_total - window_c[ring_pos] + c;
      window_c[ring_pos] = c;
      ring_pos = (ring_pos == WinLen - 1) ? 0 : ring_pos + 1;
      if (ring_pos == 0) ring_full = 1'b1;
      ac = ring_full ? round_half_away(window_total, WinLen) : 0;
      af = ring_full ? fahrenheit_of(ac) : 0;
      r.temp_c    = c[CW-1:0];
      r.temp_f    = f[FW-1:0];
      r.avg_c     = ac[CW-1:0];
      r.avg_f     = af[FW-1:0];
      r.avg_valid = ring_full;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("ERROR: result %0d: %s", results_seen, msg);
   endtask

   task automatic check_field(input string name, input logic signed [FW-1:0] got,
                              input logic signed [FW-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("result beat with no reading pending");
         end else begin
            oldest_reading = pending_readings.pop_front();
            check_field("temp_c", FW'($signed(rsp_tdata[CW-1:0])),
                        FW'(oldest_reading.temp_c));
            check_field("temp_f", $signed(rsp_tdata[TempFLsb +: FW]),
                        oldest_reading.temp_f);
            check_field("avg_c", FW'($signed(rsp_tdata[AvgCLsb +: CW])),
                        FW'(oldest_reading.avg_c));
            check_field("avg_f", $signed(rsp_tdata[AvgFLsb +: FW]),
                        oldest_reading.avg_f);
            check_field("avg_valid", FW'(rsp_tuser), FW'(oldest_reading.avg_valid));
         end
         results_seen++;
      end
   end

   // Receiver: rotate a random ready pattern, reload it now and then, and
   // hold off completely when a long stall is requested.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req_count != hold_served) begin
            hold_served = hold_req_count;
            hold_left   = LongHold;
         end
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0: ready_pattern = '1;
               1: ready_pattern = 16'($urandom());
               2: ready_pattern = 16'($urandom() | $urandom());
               default: ready_pattern = 16'($urandom() & $urandom());
            endcase
            pattern_age = $urandom_range(16, 96);
         end
         pattern_age--;
         ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ready_pattern[0];
         end
      end
   end

   // Leaves tvalid high after the beat so the next call can follow directly.
   task automatic send_sample(input logic [AdcW-1:0] adc);
      req_tvalid <= 1'b1;
      req_tdata  <= ReqDataW'(adc);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_readings.push_back(predict_reading(adc));
   endtask

   task automatic idle_gap(input int cycles);
      req_tvalid <= 1'b0;
      req_tdata  <= ReqDataW'($urandom_range(0, 4095));
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic logic [AdcW-1:0] pick_sample(input int mode);
      case (mode)
         0: return AdcW'($urandom_range(0, 4095));
         1: return AdcW'($urandom_range(0, 1100));
         2: return AdcW'($urandom_range(850, 1020));
         default: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return AdcW'(1);
               2: return AdcW'(4094);
               default: return '1;
            endcase
         end
      endcase
   endfunction

   // Extremes, the zero crossing, the window filling on the twentieth beat
   // and the ring wrapping afterwards.
   task automatic test_window_fill();
      logic [AdcW-1:0] samples [25];
      samples = '{0, 4095, 1, 4094, 12'h555, 12'hAAA, 934, 935, 933, 2048,
                  2047, 1024, 100, 3000, 4095, 0, 0, 0, 0, 0,
                  4095, 4095, 500, 12'hFFF, 7};
      foreach (samples[k]) send_sample(samples[k]);
      drain_results();
   endtask

   // Stall the output long enough that the block fills up and blocks input.
   task automatic test_output_backpressure();
      hold_req_count++;
      repeat (40) send_sample(AdcW'($urandom_range(0, 4095)));
      drain_results();
   endtask

   task automatic test_random_stream(input int n_items);
      int sent;
      int burst;
      int mode;
      int next_drain;
      sent       = 0;
      next_drain = 600;
      while (sent < n_items) begin
         burst = $urandom_range(1, 24);
         mode  = $urandom_range(0, 3);
         for (int k = 0; k < burst && sent < n_items; k++) begin
            send_sample(pick_sample(mode));
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
         if (sent >= next_drain) begin
            drain_results();
            next_drain += 600;
         end
      end
      drain_results();
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      foreach (window_c[k]) window_c[k] = 0;
      window_total   = 0;
      ring_pos       = 0;
      ring_full      = 1'b0;
      mismatch_count = 0;
      results_seen   = 0;
      hold_req_count = 0;
      hold_served    = 0;
      hold_left      = 0;
      pattern_age    = 0;
      ready_pattern  = '1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_window_fill();
      test_output_backpressure();
      test_random_stream(RandomItems);

      if (pending_readings.size() != 0)
         report_mismatch($sformatf("%0d readings never answered", pending_readings.size()));
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
